FILE: hw/rtl/efrr_pkg.sv
// Shared types, constants and the CRC-8 byte update of the frame receiver.
package efrr_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned LEN_W           = 6;
    localparam int unsigned KEPT_BYTES      = 9;
    localparam int unsigned KEPT_IDX_W      = $clog2(KEPT_BYTES);
    localparam int unsigned MAX_FRAME_BYTES = 32;
    localparam int unsigned CFG_ADDR_W      = 3;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;
    localparam logic [BYTE_W-1:0] FLAG_MASK    = 8'h03;
    localparam logic [BYTE_W-1:0] REPORT_LEN   = 8'd6;
    localparam logic [BYTE_W-1:0] HEADER_EXTRA = 8'd4;
    localparam logic [LEN_W-1:0]  MIN_LEN      = 6'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAIL_BYTE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE_BYTE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_HDR_CODE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_TL_CODE  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_ESC_CODE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_VERSION      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_REPORT_TYPE  = 3'd7;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_RECV = 2'd1,
        MODE_ESC  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] tail_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escaped_header_code;
        logic [BYTE_W-1:0] escaped_tail_code;
        logic [BYTE_W-1:0] escaped_escape_code;
        logic [BYTE_W-1:0] protocol_version;
        logic [BYTE_W-1:0] report_type;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        header_byte:         8'd255,
        tail_byte:           8'd254,
        escape_byte:         8'd253,
        escaped_header_code: 8'd1,
        escaped_tail_code:   8'd2,
        escaped_escape_code: 8'd3,
        protocol_version:    8'd1,
        report_type:         8'd1
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_header;
        logic              is_tail;
        logic              is_escape;
        logic              is_code_header;
        logic              is_code_tail;
        logic              is_code_escape;
    } tok_t;

    typedef struct packed {
        logic                     target_seen;
        logic                     sw_req_ack;
        logic [BYTE_W-1:0]        ack_id;
        logic signed [15:0]       error_x;
        logic signed [15:0]       error_y;
    } res_t;

    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/efrr_front.sv
// Front stage: accept line bytes and classify them against the configured codes.
module efrr_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  efrr_pkg::cfg_t cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_rx_byte,
    output logic           tok_valid,
    input  logic           tok_ready,
    output efrr_pkg::tok_t tok
);
    import efrr_pkg::*;

    logic vld_reg;
    logic vld_next;
    tok_t tok_reg;
    tok_t tok_next;

    assign s_ready   = !vld_reg || tok_ready;
    assign tok_valid = vld_reg;
    assign tok       = tok_reg;

    always_comb begin
        tok_next.data           = s_rx_byte;
        tok_next.is_header      = (s_rx_byte == cfg.header_byte);
        tok_next.is_tail        = (s_rx_byte == cfg.tail_byte);
        tok_next.is_escape      = (s_rx_byte == cfg.escape_byte);
        tok_next.is_code_header = (s_rx_byte == cfg.escaped_header_code);
        tok_next.is_code_tail   = (s_rx_byte == cfg.escaped_tail_code);
        tok_next.is_code_escape = (s_rx_byte == cfg.escaped_escape_code);
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (tok_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (s_valid && s_ready) begin
            tok_reg <= tok_next;
        end
    end

endmodule

FILE: hw/rtl/efrr_queue.sv
// Two-entry word queue between the classifier and the frame engine.
module efrr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  efrr_pkg::tok_t in_tok,
    output logic           out_valid,
    input  logic           out_ready,
    output efrr_pkg::tok_t out_tok
);
    import efrr_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

FILE: hw/rtl/efrr_back.sv
// Frame engine: unstuff, track length and CRC, check the frame and hold the report.
module efrr_back #(
    parameter int unsigned MAX_LEN = efrr_pkg::MAX_FRAME_BYTES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  efrr_pkg::cfg_t cfg,
    input  logic           tok_valid,
    output logic           tok_ready,
    input  efrr_pkg::tok_t tok,
    output logic           res_valid,
    input  logic           res_ready,
    output efrr_pkg::res_t res
);
    import efrr_pkg::*;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic [BYTE_W-1:0] bytes_reg [KEPT_BYTES];
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic              go;
    logic              append_en;
    logic [BYTE_W-1:0] append_val;
    logic              drop;
    logic              restart;
    logic              finish;
    logic              frame_ok;
    logic              wr_en;
    logic [BYTE_W-1:0] flags;

    assign go        = tok_valid && (!res_valid_reg || res_ready);
    assign tok_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign flags     = bytes_reg[3];

    always_comb begin
        frame_ok = (len_reg >= MIN_LEN)
                && (bytes_reg[0] == cfg.protocol_version)
                && ({3'b000, len_reg} == ({1'b0, bytes_reg[2]} + {1'b0, HEADER_EXTRA}))
                && (crc_reg == '0)
                && (bytes_reg[1] == cfg.report_type)
                && (bytes_reg[2] == REPORT_LEN)
                && ((flags & ~FLAG_MASK) == '0);
    end

    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        append_en  = 1'b0;
        append_val = tok.data;
        drop       = 1'b0;
        restart    = 1'b0;
        finish     = 1'b0;
        wr_en      = 1'b0;
        case (mode_reg)
            MODE_HUNT: begin
                if (tok.is_header) begin
                    restart   = 1'b1;
                    mode_next = MODE_RECV;
                end
            end
            MODE_RECV: begin
                if (tok.is_tail) begin
                    finish = 1'b1;
                    drop   = 1'b1;
                end else if (tok.is_header) begin
                    restart = 1'b1;
                end else if (tok.is_escape) begin
                    mode_next = MODE_ESC;
                end else begin
                    append_en = 1'b1;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_RECV;
                if (tok.is_code_header) begin
                    append_en  = 1'b1;
                    append_val = cfg.header_byte;
                end else if (tok.is_code_tail) begin
                    append_en  = 1'b1;
                    append_val = cfg.tail_byte;
                end else if (tok.is_code_escape) begin
                    append_en  = 1'b1;
                    append_val = cfg.escape_byte;
                end else begin
                    drop = 1'b1;
                end
            end
            default: begin
                drop = 1'b1;
            end
        endcase
        if (append_en) begin
            if ({26'd0, len_reg} >= 32'(MAX_LEN)) begin
                drop = 1'b1;
            end else begin
                wr_en    = (len_reg < LEN_W'(KEPT_BYTES));
                crc_next = crc8_update(crc_reg, append_val);
                len_next = len_reg + 1'b1;
            end
        end
        if (restart || drop) begin
            len_next = '0;
            crc_next = '0;
        end
        if (drop) begin
            mode_next = MODE_HUNT;
        end
    end

    always_comb begin
        res_next.target_seen = flags[0];
        res_next.sw_req_ack  = flags[1];
        res_next.ack_id      = flags[1] ? bytes_reg[8] : '0;
        res_next.error_x     = flags[0] ? {bytes_reg[5], bytes_reg[4]} : '0;
        res_next.error_y     = flags[0] ? {bytes_reg[7], bytes_reg[6]} : '0;
        if (go && finish && frame_ok) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HUNT;
            len_reg       <= '0;
            crc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (go) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                crc_reg  <= crc_next;
            end
        end
        if (go && wr_en) begin
            bytes_reg[len_reg[KEPT_IDX_W-1:0]] <= append_val;
        end
        if (go && finish && frame_ok) begin
            res_reg <= res_next;
        end
    end

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {26'd0, len_reg} <= 32'(MAX_LEN))
        else $error("frame length beyond limit");

    a_hunt_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HUNT) |-> (len_reg == '0 && crc_reg == '0))
        else $error("hunt mode with frame state left over");

    a_report_after_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid_reg) |-> $past(go && tok.is_tail && mode_reg == MODE_RECV))
        else $error("report raised without a tail word");

    a_escape_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && mode_reg == MODE_RECV && !tok.is_tail && !tok.is_header && tok.is_escape)
        |=> (mode_reg == MODE_ESC))
        else $error("escape word did not enter escape mode");

endmodule

FILE: hw/rtl/escaped_frame_report_receiver_core.sv
// Throughput: one byte per cycle unless a report waits on m_ready; the frame engine updates the
// CRC and checks the tail in one step, and a closing byte's result lands in the report register.
// A classifier register and a two-word queue decouple the input from the frame engine.
// Reset: synchronous, active low; parser hunts for a header, length and CRC clear,
// configuration returns to its defaults; the kept frame bytes are not cleared.
module escaped_frame_report_receiver_core #(
    parameter int unsigned MAX_LEN = efrr_pkg::MAX_FRAME_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [efrr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_target_seen,
    output logic                          m_sw_req_ack,
    output logic [7:0]                    m_ack_id,
    output logic signed [15:0]            m_error_x,
    output logic signed [15:0]            m_error_y
);
    import efrr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    tok_t front_tok;
    tok_t queue_tok;
    logic front_valid;
    logic front_ready;
    logic queue_valid;
    logic queue_ready;
    res_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_HEADER_BYTE:  cfg_next.header_byte         = cfg_wdata;
                REG_TAIL_BYTE:    cfg_next.tail_byte           = cfg_wdata;
                REG_ESCAPE_BYTE:  cfg_next.escape_byte         = cfg_wdata;
                REG_ESC_HDR_CODE: cfg_next.escaped_header_code = cfg_wdata;
                REG_ESC_TL_CODE:  cfg_next.escaped_tail_code   = cfg_wdata;
                REG_ESC_ESC_CODE: cfg_next.escaped_escape_code = cfg_wdata;
                REG_VERSION:      cfg_next.protocol_version    = cfg_wdata;
                REG_REPORT_TYPE:  cfg_next.report_type         = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    efrr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .tok_valid (front_valid),
        .tok_ready (front_ready),
        .tok       (front_tok)
    );

    efrr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_tok    (front_tok),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_tok   (queue_tok)
    );

    efrr_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .tok_valid (queue_valid),
        .tok_ready (queue_ready),
        .tok       (queue_tok),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_target_seen = res.target_seen;
    assign m_sw_req_ack  = res.sw_req_ack;
    assign m_ack_id      = res.ack_id;
    assign m_error_x     = res.error_x;
    assign m_error_y     = res.error_y;

endmodule

FILE: dv/tb_escaped_frame_report_receiver_core.sv
// Testbench for the escaped frame report receiver: stuffed frames in, decoded target reports checked.
module tb_escaped_frame_report_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import efrr_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [7:0]            cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_target_seen;
    logic                  m_sw_req_ack;
    logic [7:0]            m_ack_id;
    logic signed [15:0]    m_error_x;
    logic signed [15:0]    m_error_y;

    escaped_frame_report_receiver_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_target_seen (m_target_seen),
        .m_sw_req_ack  (m_sw_req_ack),
        .m_ack_id      (m_ack_id),
        .m_error_x     (m_error_x),
        .m_error_y     (m_error_y)
    );

    // frame decoder mirror
    cfg_t       cfg_model = CFG_RESET;
    mode_t      prs_mode = MODE_HUNT;
    logic [5:0] prs_len = '0;
    logic [7:0] prs_crc = '0;
    logic [7:0] prs_kept [KEPT_BYTES];
    res_t       report_q [$];

    logic [7:0] lbytes [$];
    int         errors = 0;
    int         bytes_sent = 0;
    int         reports_seen = 0;
    int         settings_used = 1;
    bit         steady = 1'b0;
    int         hold_req = 0;
    int         hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL escaped_frame_report_receiver_core");
        $finish;
    end

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void frame_restart();
        prs_len = '0;
        prs_crc = '0;
    endfunction

    function automatic void frame_drop();
        frame_restart();
        prs_mode = MODE_HUNT;
    endfunction

    function automatic bit frame_append(input logic [7:0] d);
        if (prs_len >= MAX_FRAME_BYTES) begin
            frame_drop();
            return 1'b0;
        end
        if (prs_len < KEPT_BYTES) prs_kept[prs_len] = d;
        prs_crc = crc_next(prs_crc, d);
        prs_len = prs_len + 6'd1;
        return 1'b1;
    endfunction

    function automatic void frame_close();
        res_t       r;
        logic [7:0] flags;
        if (prs_len < MIN_LEN) return;
        if (prs_kept[0] != cfg_model.protocol_version) return;
        if (int'(prs_len) != int'(prs_kept[2]) + int'(HEADER_EXTRA)) return;
        if (prs_crc != 8'h00) return;
        if (prs_kept[1] != cfg_model.report_type) return;
        if (prs_kept[2] != REPORT_LEN) return;
        flags = prs_kept[3];
        if ((flags & ~FLAG_MASK) != 8'h00) return;
        r.target_seen = flags[0];
        r.sw_req_ack  = flags[1];
        r.ack_id      = flags[1] ? prs_kept[8] : 8'h00;
        r.error_x     = flags[0] ? {prs_kept[5], prs_kept[4]} : 16'h0000;
        r.error_y     = flags[0] ? {prs_kept[7], prs_kept[6]} : 16'h0000;
        report_q.push_back(r);
    endfunction

    function automatic void predict_byte(input logic [7:0] d);
        case (prs_mode)
            MODE_HUNT: begin
                if (d == cfg_model.header_byte) begin
                    frame_restart();
                    prs_mode = MODE_RECV;
                end
            end
            MODE_RECV: begin
                if (d == cfg_model.tail_byte) begin
                    frame_close();
                    frame_drop();
                end else if (d == cfg_model.header_byte) begin
                    frame_restart();
                end else if (d == cfg_model.escape_byte) begin
                    prs_mode = MODE_ESC;
                end else begin
                    void'(frame_append(d));
                end
            end
            MODE_ESC: begin
                if (d == cfg_model.escaped_header_code) begin
                    if (frame_append(cfg_model.header_byte)) prs_mode = MODE_RECV;
                end else if (d == cfg_model.escaped_tail_code) begin
                    if (frame_append(cfg_model.tail_byte)) prs_mode = MODE_RECV;
                end else if (d == cfg_model.escaped_escape_code) begin
                    if (frame_append(cfg_model.escape_byte)) prs_mode = MODE_RECV;
                end else begin
                    frame_drop();
                end
            end
            default: begin
                frame_drop();
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_byte(s_rx_byte);
    end

    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected report, expected none, actual x=%0d y=%0d",
                         $time, m_error_x, m_error_y);
            end else begin
                want = report_q.pop_front();
                reports_seen++;
                check_field("target_seen", int'(want.target_seen), int'(m_target_seen));
                check_field("sw_req_ack", int'(want.sw_req_ack), int'(m_sw_req_ack));
                check_field("ack_id", int'(want.ack_id), int'(m_ack_id));
                check_field("error_x", int'(want.error_x), int'(m_error_x));
                check_field("error_y", int'(want.error_y), int'(m_error_y));
            end
        end
    end

    task automatic send_byte(input logic [7:0] d);
        s_valid   <= 1'b1;
        s_rx_byte <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic settle();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (report_q.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        settle();
        write_reg(REG_HEADER_BYTE, c.header_byte);
        write_reg(REG_TAIL_BYTE, c.tail_byte);
        write_reg(REG_ESCAPE_BYTE, c.escape_byte);
        write_reg(REG_ESC_HDR_CODE, c.escaped_header_code);
        write_reg(REG_ESC_TL_CODE, c.escaped_tail_code);
        write_reg(REG_ESC_ESC_CODE, c.escaped_escape_code);
        write_reg(REG_VERSION, c.protocol_version);
        write_reg(REG_REPORT_TYPE, c.report_type);
        cfg_we <= 1'b0;
        cfg_model = c;
        settings_used++;
    endtask

    task automatic build_report(input logic [7:0] flags, input logic [15:0] x,
                                input logic [15:0] y, input logic [7:0] ack);
        lbytes.delete();
        lbytes.push_back(cfg_model.protocol_version);
        lbytes.push_back(cfg_model.report_type);
        lbytes.push_back(REPORT_LEN);
        lbytes.push_back(flags);
        lbytes.push_back(x[7:0]);
        lbytes.push_back(x[15:8]);
        lbytes.push_back(y[7:0]);
        lbytes.push_back(y[15:8]);
        lbytes.push_back(ack);
    endtask

    task automatic build_other(input int n);
        lbytes.delete();
        lbytes.push_back(cfg_model.protocol_version);
        lbytes.push_back(cfg_model.report_type ^ 8'h5A);
        lbytes.push_back(n[7:0]);
        repeat (n) lbytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic seal_frame();
        logic [7:0] c;
        c = 8'h00;
        foreach (lbytes[i]) c = crc_next(c, lbytes[i]);
        lbytes.push_back(c);
    endtask

    // stuff the logical bytes in the decoder's check order
    task automatic send_frame(input bit closed);
        send_byte(cfg_model.header_byte);
        foreach (lbytes[i]) begin
            if (lbytes[i] == cfg_model.tail_byte) begin
                send_byte(cfg_model.escape_byte);
                send_byte(cfg_model.escaped_tail_code);
            end else if (lbytes[i] == cfg_model.header_byte) begin
                send_byte(cfg_model.escape_byte);
                send_byte(cfg_model.escaped_header_code);
            end else if (lbytes[i] == cfg_model.escape_byte) begin
                send_byte(cfg_model.escape_byte);
                send_byte(cfg_model.escaped_escape_code);
            end else begin
                send_byte(lbytes[i]);
            end
        end
        if (closed) send_byte(cfg_model.tail_byte);
    endtask

    task automatic send_report(input logic [7:0] flags, input logic [15:0] x,
                               input logic [15:0] y, input logic [7:0] ack);
        build_report(flags, x, y, ack);
        seal_frame();
        send_frame(1'b1);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] bad_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == cfg_model.escaped_header_code || c == cfg_model.escaped_tail_code ||
                   c == cfg_model.escaped_escape_code);
        return c;
    endfunction

    task automatic send_random_frame();
        int kind;
        int cut;
        kind = $urandom_range(0, 19);
        build_report(8'($urandom_range(0, 3)), pick_word(), pick_word(),
                     8'($urandom_range(0, 255)));
        case (kind)
            11: begin
                seal_frame();
                lbytes[9] = lbytes[9] ^ (8'h01 << $urandom_range(0, 7));
                send_frame(1'b1);
            end
            12: begin
                lbytes[0] = lbytes[0] ^ (8'h01 << $urandom_range(0, 7));
                seal_frame();
                send_frame(1'b1);
            end
            13: begin
                lbytes[2] = 8'($urandom_range(0, 255));
                if (lbytes[2] == REPORT_LEN) lbytes[2] = 8'd5;
                seal_frame();
                send_frame(1'b1);
            end
            14: begin
                lbytes[1] = lbytes[1] ^ (8'h01 << $urandom_range(0, 7));
                seal_frame();
                send_frame(1'b1);
            end
            15: begin
                lbytes[3] = lbytes[3] | (8'h04 << $urandom_range(0, 5));
                seal_frame();
                send_frame(1'b1);
            end
            16: begin
                seal_frame();
                cut = $urandom_range(0, 9);
                while (lbytes.size() > cut) void'(lbytes.pop_back());
                send_frame(1'b0);
            end
            17: begin
                send_byte(cfg_model.header_byte);
                send_byte(cfg_model.protocol_version);
                send_byte(cfg_model.escape_byte);
                send_byte(bad_code());
                send_byte(8'($urandom_range(0, 255)));
            end
            18: begin
                build_other($urandom_range(0, 30));
                seal_frame();
                send_frame(1'b1);
            end
            19: begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                seal_frame();
                send_frame(1'b1);
            end
        endcase
    endtask

    task automatic test_report_fields();
        send_report(8'h00, 16'h1234, 16'h5678, 8'h9A);
        send_report(8'h01, 16'h8000, 16'h7FFF, 8'hFF);
        send_report(8'h02, 16'h7FFF, 16'h8000, 8'h00);
        send_report(8'h03, 16'hFFFF, 16'h0000, 8'hFF);
        send_report(8'h03, 16'h0000, 16'hFFFF, 8'h01);
        settle();
    endtask

    task automatic test_escape_codes();
        logic [7:0] specials [3];
        logic [7:0] c;
        specials = '{cfg_model.header_byte, cfg_model.tail_byte, cfg_model.escape_byte};
        send_report(8'h03, {cfg_model.header_byte, cfg_model.tail_byte},
                    {cfg_model.escape_byte, cfg_model.escape_byte}, cfg_model.tail_byte);
        // steer the check byte onto each reserved value
        foreach (specials[k]) begin
            for (int a = 0; a < 256; a++) begin
                build_report(8'h03, 16'h0102, 16'h0304, 8'(a));
                c = 8'h00;
                foreach (lbytes[i]) c = crc_next(c, lbytes[i]);
                if (c == specials[k]) break;
            end
            seal_frame();
            send_frame(1'b1);
        end
        settle();
    endtask

    task automatic test_malformed_frames();
        lbytes.delete();
        send_frame(1'b1);
        lbytes = '{cfg_model.protocol_version, cfg_model.report_type, 8'h00};
        send_frame(1'b1);
        seal_frame();
        send_frame(1'b1);
        build_report(8'h01, 16'h1111, 16'h2222, 8'h33);
        seal_frame();
        lbytes[9] = lbytes[9] ^ 8'h01;
        send_frame(1'b1);
        build_report(8'h01, 16'h1111, 16'h2222, 8'h33);
        lbytes[0] = lbytes[0] ^ 8'h80;
        seal_frame();
        send_frame(1'b1);
        build_report(8'h01, 16'h1111, 16'h2222, 8'h33);
        lbytes[2] = 8'd7;
        seal_frame();
        send_frame(1'b1);
        build_report(8'h01, 16'h1111, 16'h2222, 8'h33);
        lbytes[1] = lbytes[1] ^ 8'h01;
        seal_frame();
        send_frame(1'b1);
        send_report(8'h04, 16'h1111, 16'h2222, 8'h33);
        send_report(8'h80, 16'h1111, 16'h2222, 8'h33);
        // header inside a frame restarts it
        lbytes = '{cfg_model.protocol_version, cfg_model.report_type, REPORT_LEN};
        send_frame(1'b0);
        send_report(8'h03, 16'hABCD, 16'h0123, 8'h44);
        send_byte(cfg_model.header_byte);
        send_byte(cfg_model.protocol_version);
        send_byte(cfg_model.escape_byte);
        send_byte(cfg_model.header_byte);
        send_byte(cfg_model.tail_byte);
        build_other(28);
        seal_frame();
        send_frame(1'b1);
        build_other(29);
        seal_frame();
        send_frame(1'b1);
        build_other(28);
        seal_frame();
        lbytes.push_back(cfg_model.escape_byte);
        send_frame(1'b1);
        send_report(8'h01, 16'h0F0F, 16'hF0F0, 8'h55);
        settle();
    endtask

    task automatic test_output_stall();
        steady = 1'b1;
        hold_req = 300;
        repeat (20) send_report(8'($urandom_range(0, 3)), pick_word(), pick_word(),
                                8'($urandom_range(0, 255)));
        settle();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_bytes, input bit no_gaps);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        steady = no_gaps;
        while (bytes_sent < stop_at) send_random_frame();
        settle();
        steady = 1'b0;
    endtask

    task automatic test_register_extremes();
        load_config('{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00});
        test_escape_codes();
        test_random_traffic(60, 1'b0);
        load_config('{8'hFF, 8'h00, 8'h7F, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF});
        test_escape_codes();
        test_random_traffic(60, 1'b0);
    endtask

    task automatic test_random_registers();
        cfg_t rc;
        repeat (2) begin
            rc = {$urandom(), $urandom()};
            load_config(rc);
            test_random_traffic(50, 1'b0);
        end
        rc = {$urandom(), $urandom()};
        rc.tail_byte = rc.header_byte;
        load_config(rc);
        test_random_traffic(40, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_report_fields();
        test_escape_codes();
        test_malformed_frames();
        test_output_stall();
        test_random_traffic(200, 1'b1);
        test_random_traffic(100, 1'b0);
        test_register_extremes();
        test_random_registers();
        load_config(CFG_RESET);
        test_random_traffic(1450 - bytes_sent, 1'b0);
        settle();
        if (report_q.size() != 0) begin
            errors++;
            $display("%0t ns: expected %0d more reports, actual 0", $time, report_q.size());
        end
        $display("Sent %0d line bytes, checked %0d reports over %0d register settings,",
                 bytes_sent, reports_seen, settings_used);
        $display("with escapes, broken and overlong frames, idle gaps and a long output stall.");
        if (errors == 0) begin
            $display("PASS escaped_frame_report_receiver_core");
        end else begin
            $display("FAIL escaped_frame_report_receiver_core");
        end
        $finish;
    end

endmodule
